@@ rtl/core/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation codes and the item record passed from front end to back end.
// ----------------------------------------------------------------------------
package rau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_LT  = 3'd4,
    OP_LE  = 3'd5,
    OP_GT  = 3'd6,
    OP_GE  = 3'd7
  } op_e;

  localparam int unsigned ProdW = 64;
  localparam int unsigned NumOutW = 33;
  localparam int unsigned DenOutW = 31;

  // Classified item handed from front end to back end
  typedef struct packed {
    logic             is_cmp;
    logic             cmp_res;
    logic [ProdW-1:0] num;
    logic [ProdW-1:0] den;
  } item_t;

endpackage

@@ rtl/core/rau_front.sv @@
// ----------------------------------------------------------------------------
// rau_front: operand intake and cross products
// Forms the exact cross products one at a time with one multiplier,
// then builds the unreduced numerator/denominator or the compare bit.
// ----------------------------------------------------------------------------
module rau_front #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               mode_i,
  input  logic [OPERAND_WIDTH-1:0] a_num_i,
  input  logic [OPERAND_WIDTH-1:0] a_den_i,
  input  logic [OPERAND_WIDTH-1:0] b_num_i,
  input  logic [OPERAND_WIDTH-1:0] b_den_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output rau_pkg::item_t           out_item_o
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_COMB = 4'b0100,
    F_OUT  = 4'b1000
  } fstate_e;

  fstate_e state_q, state_d;
  logic [1:0] step_q;
  logic [2:0] mode_q;
  logic [OPERAND_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic [rau_pkg::ProdW-1:0] p_q [4];
  logic [OPERAND_WIDTH-1:0] ma, mb;
  logic signed [2*OPERAND_WIDTH-1:0] prod;
  logic [rau_pkg::ProdW-1:0] mp;
  rau_pkg::item_t item_q, item_d;
  logic [rau_pkg::ProdW-1:0] sum, dif;

  // Operand selection for the shared multiplier: an*bd, bn*ad, an*bn, ad*bd
  always_comb begin
    case (step_q)
      2'd0: begin ma = an_q; mb = bd_q; end
      2'd1: begin ma = bn_q; mb = ad_q; end
      2'd2: begin ma = an_q; mb = bn_q; end
      default: begin ma = ad_q; mb = bd_q; end
    endcase
  end

  // Operand-width signed product, sign-extended to the product width
  assign prod = $signed(ma) * $signed(mb);
  assign mp   = rau_pkg::ProdW'(prod);
  assign sum  = p_q[0] + p_q[1];
  assign dif  = p_q[0] - p_q[1];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (in_valid_i) state_d = F_MUL;
      F_MUL:  if (step_q == 2'd3) state_d = F_COMB;
      F_COMB: state_d = F_OUT;
      F_OUT:  if (out_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      if (state_q == F_MUL) step_q <= step_q + 2'd1;
      else step_q <= 2'd0;
    end
  end

  // Combine products into the record for the back end
  always_comb begin
    item_d        = '0;
    item_d.is_cmp = mode_q[2];
    item_d.den    = p_q[3];
    unique case (rau_pkg::op_e'(mode_q))
      rau_pkg::OP_ADD: item_d.num = sum;
      rau_pkg::OP_SUB: item_d.num = dif;
      rau_pkg::OP_MUL: item_d.num = p_q[2];
      rau_pkg::OP_DIV: begin
        item_d.num = p_q[0];
        item_d.den = p_q[1];
      end
      rau_pkg::OP_LT: item_d.cmp_res = $signed(p_q[0]) < $signed(p_q[1]);
      rau_pkg::OP_LE: item_d.cmp_res = !($signed(p_q[1]) < $signed(p_q[0]));
      rau_pkg::OP_GT: item_d.cmp_res = $signed(p_q[1]) < $signed(p_q[0]);
      default:        item_d.cmp_res = !($signed(p_q[0]) < $signed(p_q[1]));
    endcase
  end

  // Capture operands, products, and the combined record
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      mode_q <= mode_i;
      an_q <= a_num_i;
      ad_q <= a_den_i;
      bn_q <= b_num_i;
      bd_q <= b_den_i;
    end
    if (state_q == F_MUL) p_q[step_q] <= mp;
    if (state_q == F_COMB) item_q <= item_d;
  end

  assign in_ready_o  = (state_q == F_IDLE);
  assign out_valid_o = (state_q == F_OUT);
  assign out_item_o  = item_q;

endmodule

@@ rtl/core/rau_queue.sv @@
// ----------------------------------------------------------------------------
// rau_queue: two-entry queue between front end and back end
// Lets either side stall on its own.
// ----------------------------------------------------------------------------
module rau_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rau_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rau_pkg::item_t out_item_o
);

  rau_pkg::item_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

endmodule

@@ rtl/core/rau_back.sv @@
// ----------------------------------------------------------------------------
// rau_back: reduction engine
// Binary-restoring remainder for Euclid's gcd, then two exact divisions
// by the gcd, one quotient bit per cycle, and sign placement.
// ----------------------------------------------------------------------------
module rau_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rau_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [rau_pkg::NumOutW-1:0] result_num_o,
  output logic [rau_pkg::DenOutW-1:0] result_den_o,
  output logic           compare_true_o,
  output logic           status_o
);

  localparam int unsigned W = rau_pkg::ProdW;
  localparam int unsigned CntW = $clog2(W);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_GSTA = 7'b0000010,
    B_GMOD = 7'b0000100,
    B_DSTA = 7'b0001000,
    B_DIV  = 7'b0010000,
    B_FIN  = 7'b0100000,
    B_OUT  = 7'b1000000
  } bstate_e;

  bstate_e state_q;
  logic [W-1:0] nm_q, dm_q, ga_q, gb_q;
  logic [W-1:0] rem_q, quo_q, dvd_q, dsr_q;
  logic [CntW-1:0] cnt_q;
  logic sel_q, neg_q;
  logic [W-1:0] qn_q;
  logic [W:0] trial;
  logic [W-1:0] rem_sh;
  logic [rau_pkg::NumOutW-1:0] rnum_q;
  logic [rau_pkg::DenOutW-1:0] rden_q;
  logic cmp_q, st_q;

  // One restoring division step: shift in next dividend bit, try subtract
  assign rem_sh = {rem_q[W-2:0], dvd_q[W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      unique case (state_q)
        B_IDLE: if (in_valid_i) begin
          if (in_item_i.is_cmp || in_item_i.den == '0) state_q <= B_OUT;
          else state_q <= B_GSTA;
        end
        B_GSTA: state_q <= (gb_q == '0) ? B_DSTA : B_GMOD;
        B_GMOD: if (cnt_q == CntW'(W - 1)) state_q <= B_GSTA;
        B_DSTA: state_q <= B_DIV;
        B_DIV:  if (cnt_q == CntW'(W - 1)) state_q <= sel_q ? B_FIN : B_DSTA;
        B_FIN:  state_q <= B_OUT;
        B_OUT:  if (out_ready_i) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: if (in_valid_i) begin
        nm_q  <= in_item_i.num[W-1] ? -in_item_i.num : in_item_i.num;
        dm_q  <= in_item_i.den[W-1] ? -in_item_i.den : in_item_i.den;
        ga_q  <= in_item_i.num[W-1] ? -in_item_i.num : in_item_i.num;
        gb_q  <= in_item_i.den[W-1] ? -in_item_i.den : in_item_i.den;
        neg_q <= in_item_i.num[W-1] ^ in_item_i.den[W-1];
        cmp_q <= in_item_i.cmp_res;
        sel_q <= 1'b0;
        st_q  <= !in_item_i.is_cmp && (in_item_i.den == '0);
        rnum_q <= in_item_i.is_cmp ? '0 : in_item_i.num[rau_pkg::NumOutW-1:0];
        rden_q <= '0;
      end
      // Start ga mod gb
      B_GSTA: begin
        rem_q <= '0;
        dvd_q <= ga_q;
        dsr_q <= gb_q;
        cnt_q <= '0;
      end
      B_GMOD: begin
        rem_q <= trial[W] ? rem_sh : trial[W-1:0];
        dvd_q <= {dvd_q[W-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(W - 1)) begin
          ga_q <= gb_q;
          gb_q <= trial[W] ? rem_sh : trial[W-1:0];
        end
      end
      // Divide numerator, then denominator, by the gcd in ga
      B_DSTA: begin
        rem_q <= '0;
        quo_q <= '0;
        dvd_q <= sel_q ? dm_q : nm_q;
        dsr_q <= ga_q;
        cnt_q <= '0;
      end
      B_DIV: begin
        rem_q <= trial[W] ? rem_sh : trial[W-1:0];
        dvd_q <= {dvd_q[W-2:0], 1'b0};
        quo_q <= {quo_q[W-2:0], ~trial[W]};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(W - 1)) begin
          if (!sel_q) qn_q <= {quo_q[W-2:0], ~trial[W]};
          else rden_q <= {quo_q[rau_pkg::DenOutW-2:0], ~trial[W]};
          sel_q <= 1'b1;
        end
      end
      B_FIN: rnum_q <= neg_q ? (-qn_q[rau_pkg::NumOutW-1:0])
                             : qn_q[rau_pkg::NumOutW-1:0];
      default: ;
    endcase
  end

  assign in_ready_o     = (state_q == B_IDLE);
  assign out_valid_o    = (state_q == B_OUT);
  assign result_num_o   = rnum_q;
  assign result_den_o   = rden_q;
  assign compare_true_o = cmp_q && !st_q;
  assign status_o       = st_q;

endmodule

@@ rtl/core/rational_arith_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arith_unit: exact add/sub/mul/div/compare of signed fractions
// Front end forms cross products, back end reduces by gcd.
// ----------------------------------------------------------------------------
// Path: compares and zero denominators skip the gcd and the divisions in the
// back end; arithmetic runs the Euclid remainder steps and then two divisions
// by the gcd, each one bit per cycle on the 64-bit datapath.
// Throughput: one item per back-end pass; the front end works ahead by up to
// three items (one held at its output, two queued).
// Reset: asynchronous active-low rst_ni clears the state machines, the front-end step counter and the queue pointers.
module rational_arith_unit #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // mode[2:0], a_num, a_den, b_num, b_den, zero pad
  input  logic [((3 + 4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // result_num[32:0], result_den[63:33], compare_true[64], status[65], pad
  output logic [71:0] m_axis_tdata
);

  localparam int unsigned OW = OPERAND_WIDTH;

  logic f_valid, f_ready, q_valid, q_ready;
  rau_pkg::item_t f_item, q_item;
  logic [rau_pkg::NumOutW-1:0] r_num;
  logic [rau_pkg::DenOutW-1:0] r_den;
  logic r_cmp, r_st;

  rau_front #(.OPERAND_WIDTH(OW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tdata[2:0]),
    .a_num_i    (s_axis_tdata[3 +: OW]),
    .a_den_i    (s_axis_tdata[3 + OW +: OW]),
    .b_num_i    (s_axis_tdata[3 + 2 * OW +: OW]),
    .b_den_i    (s_axis_tdata[3 + 3 * OW +: OW]),
    .out_valid_o(f_valid),
    .out_ready_i(f_ready),
    .out_item_o (f_item)
  );

  rau_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .in_item_i  (f_item),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_item_o (q_item)
  );

  rau_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i    (q_valid),
    .in_ready_o    (q_ready),
    .in_item_i     (q_item),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .result_num_o  (r_num),
    .result_den_o  (r_den),
    .compare_true_o(r_cmp),
    .status_o      (r_st)
  );

  assign m_axis_tdata = {6'd0, r_st, r_cmp, r_den, r_num};

  // Error results never carry a denominator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[65] |-> m_axis_tdata[63:33] == '0)
    else $error("error result with nonzero denominator");

  // Compare flag and error flag are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[64] && m_axis_tdata[65]))
    else $error("compare and error both set");

  // Ok arithmetic result has a positive denominator, or is a compare
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[65] && m_axis_tdata[63:33] == '0
      |-> m_axis_tdata[32:0] == '0)
    else $error("zero denominator without error flag");

endmodule

@@ verif/rau_checker.sv @@
// ----------------------------------------------------------------------------
// rau_checker: predictor and scoreboard for the rational arithmetic unit
// Watches both stream channels. For each input transfer it computes the
// reduced fraction or the compare bit. It then checks every output transfer
// in order against those predictions.
// ----------------------------------------------------------------------------
module rau_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [71:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [71:0] m_tdata_i,
  output int          mismatches_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        status;
    logic        cmp_true;
    logic [30:0] den;
    logic [32:0] num;
  } fraction_t;

  fraction_t expected_q[$];

  // Exact rational result of one request
  function automatic fraction_t rational_result(logic [71:0] req);
    rau_pkg::op_e        op;
    longint              an, ad, bn, bd, lhs, rhs, num, den;
    longint unsigned     nm, dm, g, x, y, t;
    fraction_t           r;
    op = rau_pkg::op_e'(req[2:0]);
    an = longint'($signed(req[18:3]));
    ad = longint'($signed(req[34:19]));
    bn = longint'($signed(req[50:35]));
    bd = longint'($signed(req[66:51]));
    r  = '0;
    // compares: raw cross products, no sign fixup of denominators
    if (op inside {rau_pkg::OP_LT, rau_pkg::OP_LE, rau_pkg::OP_GT, rau_pkg::OP_GE}) begin
      lhs = an * bd;
      rhs = bn * ad;
      case (op)
        rau_pkg::OP_LT: r.cmp_true = lhs < rhs;
        rau_pkg::OP_LE: r.cmp_true = lhs <= rhs;
        rau_pkg::OP_GT: r.cmp_true = lhs > rhs;
        default:        r.cmp_true = lhs >= rhs;
      endcase
      return r;
    end
    case (op)
      rau_pkg::OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
      rau_pkg::OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
      rau_pkg::OP_MUL: begin num = an * bn;           den = ad * bd; end
      default:         begin num = an * bd;           den = ad * bn; end
    endcase
    // zero denominator: unreduced numerator, error flagged
    if (den == 0) begin
      r.num    = num[32:0];
      r.status = 1'b1;
      return r;
    end
    nm = (num < 0) ? longint'(-num) : num;
    dm = (den < 0) ? longint'(-den) : den;
    x  = nm;
    y  = dm;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    g  = x;
    nm = nm / g;
    dm = dm / g;
    if ((num < 0) != (den < 0)) nm = -nm;
    r.num = nm[32:0];
    r.den = dm[30:0];
    return r;
  endfunction

  // Predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    fraction_t want, got;
    if (!rst_ni) begin
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) expected_q.push_back(rational_result(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[65:0];
        if (expected_q.size() == 0) begin
          if (mismatches_o < 10) $display("unexpected result %h", m_tdata_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (mismatches_o < 10)
              $display("mismatch: num %0d/%0d den %0d/%0d cmp %b/%b status %b/%b (exp/act)",
                       $signed(want.num), $signed(got.num), want.den, got.den,
                       want.cmp_true, got.cmp_true, want.status, got.status);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      outstanding_o <= expected_q.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the rational arithmetic unit
// Drives directed corner fractions and then random ones, with random idle
// bursts on both channels. Checking is done in rau_checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomCount = 1030;
  localparam longint CycleLimit = 12_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        idle_on = 1'b1;
  int          mismatches, outstanding;
  int          stall_left = 0;
  longint      cycles = 0;

  always #6 clk_i = ~clk_i;

  rational_arith_unit #(.OPERAND_WIDTH(16)) u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata)
  );

  rau_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  // Run-away guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Receiver backpressure in bursts
  always @(posedge clk_i) begin
    if (!idle_on) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 14) - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // One input transfer, optionally followed by an idle burst
  task automatic send_fraction_pair(rau_pkg::op_e op, logic [15:0] an, logic [15:0] ad,
                                    logic [15:0] bn, logic [15:0] bd);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, bd, bn, ad, an, op};
    do @(posedge clk_i); while (!s_tready);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Operand that is often small so reductions are nontrivial
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9)) inside
      0:       return '0;
      [1:2]:   return 16'($urandom_range(0, 2)) - 16'd1;
      [3:5]:   return 16'($signed($urandom_range(0, 48)) - 24);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    rau_pkg::op_e op;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: extremes, every op, zero denominators, zero result
    for (int k = 0; k < 8; k++) begin
      op = rau_pkg::op_e'(k);
      send_fraction_pair(op, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
    end
    send_fraction_pair(rau_pkg::OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8001);
    send_fraction_pair(rau_pkg::OP_MUL, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
    send_fraction_pair(rau_pkg::OP_DIV, 16'h8000, 16'hffff, 16'h8001, 16'h7fff);
    send_fraction_pair(rau_pkg::OP_ADD, 16'd3, 16'd0, 16'd1, 16'd2);
    send_fraction_pair(rau_pkg::OP_SUB, 16'd3, 16'd4, 16'd1, 16'd0);
    send_fraction_pair(rau_pkg::OP_MUL, 16'hffff, 16'd0, 16'd5, 16'd0);
    send_fraction_pair(rau_pkg::OP_DIV, 16'd3, 16'd4, 16'd0, 16'd7);
    send_fraction_pair(rau_pkg::OP_DIV, 16'd3, 16'd0, 16'd2, 16'd7);
    send_fraction_pair(rau_pkg::OP_SUB, 16'd2, 16'd4, 16'd1, 16'd2);
    send_fraction_pair(rau_pkg::OP_MUL, 16'd0, 16'hfffd, 16'd9, 16'd4);
    send_fraction_pair(rau_pkg::OP_ADD, 16'd1, 16'hfffe, 16'd1, 16'd3);
    send_fraction_pair(rau_pkg::OP_LT, 16'd1, 16'hfffe, 16'd1, 16'd2);
    send_fraction_pair(rau_pkg::OP_GE, 16'd0, 16'd0, 16'd0, 16'd0);
    send_fraction_pair(rau_pkg::OP_LE, 16'd2, 16'd4, 16'd1, 16'd2);

    // Hold off until the unit has drained
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);

    // Random fractions; idling stops for the tail of the run
    for (int n = 0; n < RandomCount; n++) begin
      if (n == RandomCount - 100) idle_on <= 1'b0;
      op = rau_pkg::op_e'($urandom_range(0, 7));
      send_fraction_pair(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    s_tvalid <= 1'b0;
    @(posedge clk_i);

    wait (outstanding == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
